>>> hdl/lad_pkg.sv
// Shared types and constants for the linear array deque.
package lad_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = 5;
  localparam int EXT_W  = (PTR_W > IDX_W) ? PTR_W : IDX_W;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [1:0] {
    REQ_PUSH_REAR  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REAR_FULL  = 2'd1,
    ST_FRONT_FULL = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] pop_value;
    idx_t               front_index;
    idx_t               rear_index;
  } res_t;

  localparam ptr_t DEPTH_PTR = PTR_W'(DEPTH);

  function automatic idx_t to_idx(input ptr_t p);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(p);
    return ext[IDX_W-1:0];
  endfunction

  function automatic addr_t pos_to_addr(input ptr_t p);
    ptr_t q;
    q = p - PTR_W'(1);
    return q[ADDR_W-1:0];
  endfunction

endpackage

>>> hdl/linear_array_deque.sv
// Linear array deque top level: request register, engine and result register.
// Each accepted request waits in the request register while the engine
// resolves it against the pointer registers and the flip-flop entry store; the result
// register loads from the engine when the request advances, and a new request can be
// accepted every cycle while results drain. When a result waits, one further request is
// held in the request register and s_tready drops until the result is taken. Requests
// are resolved in order, so each sees the latest state.
module linear_array_deque (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // push_value[31:0]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pop_value[31:0], front_index[36:32], rear_index[41:37]
  output logic [1:0]  m_tuser    // status[1:0]
);

  logic          in_valid;
  lad_pkg::req_t in_req;
  lad_pkg::res_t eng_res;
  lad_pkg::res_t out_res;
  logic          advance;
  logic          s_fire;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_req.req_type   <= lad_pkg::req_kind_t'(s_tuser);
      in_req.push_value <= s_tdata;
    end
  end

  lad_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (in_req),
    .res  (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= eng_res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {6'd0, out_res.rear_index, out_res.front_index, out_res.pop_value};

endmodule

>>> hdl/lad_engine.sv
// Deque pointers, entry storage and the per-request update logic.
module lad_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  lad_pkg::req_t req,
  output lad_pkg::res_t res
);

  logic [31:0]   store [lad_pkg::DEPTH];
  lad_pkg::ptr_t front_ptr;
  lad_pkg::ptr_t rear_ptr;
  lad_pkg::ptr_t front_next;
  lad_pkg::ptr_t rear_next;
  lad_pkg::ptr_t rd_pos;
  lad_pkg::ptr_t wr_pos;
  logic          wr_en;
  logic [31:0]   rd_data;
  lad_pkg::status_t status;
  logic [31:0]   popped;

  assign rd_pos  = (req.req_type == lad_pkg::REQ_POP_FRONT) ? front_ptr : rear_ptr;
  assign rd_data = store[lad_pkg::pos_to_addr(rd_pos)];

  always_comb begin
    front_next = front_ptr;
    rear_next  = rear_ptr;
    status     = lad_pkg::ST_OK;
    popped     = '0;
    wr_en      = 1'b0;
    wr_pos     = rear_ptr + lad_pkg::PTR_W'(1);
    unique case (req.req_type)
      lad_pkg::REQ_PUSH_REAR: begin
        if (rear_ptr == lad_pkg::DEPTH_PTR) begin
          status = lad_pkg::ST_REAR_FULL;
        end else begin
          rear_next = rear_ptr + lad_pkg::PTR_W'(1);
          wr_en     = 1'b1;
          if (rear_ptr == '0 && front_ptr == '0) begin
            front_next = lad_pkg::PTR_W'(1);
          end
        end
      end
      lad_pkg::REQ_PUSH_FRONT: begin
        wr_pos = front_ptr - lad_pkg::PTR_W'(1);
        if (front_ptr <= lad_pkg::PTR_W'(1)) begin
          status = lad_pkg::ST_FRONT_FULL;
        end else begin
          front_next = front_ptr - lad_pkg::PTR_W'(1);
          wr_en      = 1'b1;
        end
      end
      lad_pkg::REQ_POP_FRONT: begin
        if (front_ptr == '0) begin
          status = lad_pkg::ST_EMPTY;
        end else begin
          popped = rd_data;
          if (front_ptr == rear_ptr) begin
            front_next = '0;
            rear_next  = '0;
          end else begin
            front_next = front_ptr + lad_pkg::PTR_W'(1);
          end
        end
      end
      lad_pkg::REQ_POP_REAR: begin
        if (rear_ptr == '0) begin
          status = lad_pkg::ST_EMPTY;
        end else begin
          popped = rd_data;
          if (front_ptr == rear_ptr) begin
            front_next = '0;
            rear_next  = '0;
          end else begin
            rear_next = rear_ptr - lad_pkg::PTR_W'(1);
          end
        end
      end
      default: begin
        status = lad_pkg::ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr <= '0;
      rear_ptr  <= '0;
    end else if (fire) begin
      front_ptr <= front_next;
      rear_ptr  <= rear_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      store[lad_pkg::pos_to_addr(wr_pos)] <= req.push_value;
    end
  end

  assign res.status      = status;
  assign res.pop_value   = popped;
  assign res.front_index = lad_pkg::to_idx(front_next);
  assign res.rear_index  = lad_pkg::to_idx(rear_next);

  a_empty_both: assert property (@(posedge clk) disable iff (rst)
    (front_ptr == '0) == (rear_ptr == '0))
    else $error("front and rear disagree on empty");

  a_order: assert property (@(posedge clk) disable iff (rst)
    front_ptr <= rear_ptr && rear_ptr <= lad_pkg::DEPTH_PTR)
    else $error("pointer order broken");

  a_fail_hold: assert property (@(posedge clk) disable iff (rst)
    fire && status != lad_pkg::ST_OK |=> $stable(front_ptr) && $stable(rear_ptr))
    else $error("failed request moved a pointer");

  a_push_rear: assert property (@(posedge clk) disable iff (rst)
    fire && status == lad_pkg::ST_OK && req.req_type == lad_pkg::REQ_PUSH_REAR
    |=> rear_ptr == $past(rear_ptr) + lad_pkg::PTR_W'(1))
    else $error("rear push did not advance rear");

endmodule
